// ===== src/rsp_pkg.sv =====
// Shared types and constants for the RGB status pattern generator.
// No dependencies; imported by the core and its checker.
`default_nettype none

package rsp_pkg;

    // Color channel width
    localparam int LEVEL_W = 8;

    typedef logic [LEVEL_W-1:0] t_level;

    // Pattern commands carried by an input beat
    typedef enum logic [3:0] {
        CMD_GPS          = 4'd0,
        CMD_ACC_CAL      = 4'd1,
        CMD_MAG_CAL      = 4'd2,
        CMD_CONFIG       = 4'd3,
        CMD_ESC          = 4'd4,
        CMD_PREARM_INIT  = 4'd5,
        CMD_PREARM_OK    = 4'd6,
        CMD_PREARM_FAIL  = 4'd7,
        CMD_GYRO         = 4'd8
    } t_cmd;

    // Configuration register indexes
    localparam logic [2:0] CFG_FULL_LEVEL   = 3'd0;
    localparam logic [2:0] CFG_GYRO_STEP    = 3'd1;
    localparam logic [2:0] CFG_CONFIG_BLINK = 3'd2;
    localparam logic [2:0] CFG_ESC_STEP     = 3'd3;
    localparam logic [2:0] CFG_GPS_FAIL     = 3'd4;
    localparam logic [2:0] CFG_GPS_BLINK    = 3'd5;

    // Configuration reset values
    localparam t_level      FULL_LEVEL_RST   = t_level'(254);
    localparam logic [15:0] GYRO_STEP_RST    = 16'd250;
    localparam logic [15:0] CONFIG_BLINK_RST = 16'd500;
    localparam logic [15:0] ESC_STEP_RST     = 16'd170;
    localparam logic [15:0] GPS_FAIL_RST     = 16'd350;
    localparam logic [15:0] GPS_BLINK_RST    = 16'd150;

    // Fixed color levels
    localparam t_level LVL_OFF    = t_level'(0);
    localparam t_level LVL_BLUE   = t_level'(220);
    localparam t_level LVL_RED_LO = t_level'(180);
    localparam t_level LVL_YEL_R  = t_level'(190);
    localparam t_level LVL_YEL_G  = t_level'(240);

    // RTH blink: us % 100000 > 50000.
    // 100000 = 32 * 3125, so with h = us >> 5 and m = h % 3125 the test is
    // m > 1562, or m == 1562 and us[4:0] > 16.
    // h / 3125 = (h * RECIP_M) >> RECIP_SHIFT, exact for h < 2^27.
    localparam logic [27:0] RECIP_M     = 28'd175921861;
    localparam int          RECIP_SHIFT = 39;
    localparam logic [11:0] SUB_DIV     = 12'd3125;
    localparam logic [11:0] HALF_HI     = 12'd1562;
    localparam logic [4:0]  HALF_LO     = 5'd16;

    // Satellite count limit when eight or more are tracked
    localparam logic [7:0] BLINK_LIMIT_8 = 8'd16;
    localparam logic [7:0] BLINK_GREEN_MIN = 8'd10;
    localparam logic [7:0] BLINK_HOME    = 8'd6;

    // ESC flasher steps
    localparam logic [2:0] ESC_RED   = 3'd1;
    localparam logic [2:0] ESC_GREEN = 3'd2;
    localparam logic [2:0] ESC_BLUE  = 3'd3;
    localparam logic [2:0] ESC_OFF_A = 3'd4;
    localparam logic [2:0] ESC_OFF_B = 3'd5;
    localparam logic [2:0] ESC_WRAP  = 3'd6;

    // Elapsed-time test with 32-bit wrap
    function automatic logic due(input logic [31:0] now, input logic [31:0] stamp,
                                 input logic [15:0] interval);
        logic [31:0] diff;
        diff = now - stamp;
        return diff >= {16'd0, interval};
    endfunction

endpackage

`default_nettype wire

// ===== src/rgb_status_pattern_generator_core.sv =====
// RGB status pattern generator: each accepted input beat yields one result beat;
// one beat accepted per cycle, sustained, whenever the output is taken.
// Stages: input register, RTH phase reciprocal multiply, remainder compare, pattern
// state update into the held-color output register. Rate is set by the pattern state
// loop. Synchronous active-low reset clears pipeline valids, pattern state and held
// color, and loads the configuration defaults.
// Depends on rsp_pkg.
`default_nettype none

module rgb_status_pattern_generator_core
    import rsp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [3:0]         i_command,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic [31:0]        i_now_us,
    input  wire logic               i_gps_bad,
    input  wire logic               i_gps_good,
    input  wire logic               i_gps_eight_plus,
    input  wire logic [5:0]         i_satellites,
    input  wire logic               i_rth_active,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [LEVEL_W-1:0]      o_red_level,
    output logic [LEVEL_W-1:0]      o_green_level,
    output logic [LEVEL_W-1:0]      o_blue_level,
    // configuration channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    // fields carried down the pipe
    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] now;
        logic        bad;
        logic        good;
        logic        eight;
        logic [5:0]  sats;
        logic        rth;
    } t_item;

    // ---------------- configuration ----------------
    t_level      r_full_level;
    logic [15:0] r_gyro_step_ms, r_config_blink_ms, r_esc_step_ms;
    logic [15:0] r_gps_fail_ms, r_gps_blink_ms;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_level      <= FULL_LEVEL_RST;
            r_gyro_step_ms    <= GYRO_STEP_RST;
            r_config_blink_ms <= CONFIG_BLINK_RST;
            r_esc_step_ms     <= ESC_STEP_RST;
            r_gps_fail_ms     <= GPS_FAIL_RST;
            r_gps_blink_ms    <= GPS_BLINK_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_FULL_LEVEL)   r_full_level      <= i_cfg_data[LEVEL_W-1:0];
            if (i_cfg_index == CFG_GYRO_STEP)    r_gyro_step_ms    <= i_cfg_data;
            if (i_cfg_index == CFG_CONFIG_BLINK) r_config_blink_ms <= i_cfg_data;
            if (i_cfg_index == CFG_ESC_STEP)     r_esc_step_ms     <= i_cfg_data;
            if (i_cfg_index == CFG_GPS_FAIL)     r_gps_fail_ms     <= i_cfg_data;
            if (i_cfg_index == CFG_GPS_BLINK)    r_gps_blink_ms    <= i_cfg_data;
        end
    end

    // ---------------- pipeline flow control ----------------
    logic r_v1, r_v2, r_v3, r_out_valid;
    logic w_en1, w_en2, w_en3, w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_en3      = !r_v3 || w_out_free;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1)      r_v1        <= i_in_valid;
            if (w_en2)      r_v2        <= r_v1;
            if (w_en3)      r_v3        <= r_v2;
            if (w_out_free) r_out_valid <= r_v3;
        end
    end

    // ---------------- stage 1: input register ----------------
    t_item       r_s1;
    logic [31:0] r_s1_us;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1.cmd   <= i_command;
            r_s1.now   <= i_now_ms;
            r_s1.bad   <= i_gps_bad;
            r_s1.good  <= i_gps_good;
            r_s1.eight <= i_gps_eight_plus;
            r_s1.sats  <= i_satellites;
            r_s1.rth   <= i_rth_active;
            r_s1_us    <= i_now_us;
        end
    end

    // ---------------- stage 2: quotient of (us >> 5) / 3125 ----------------
    logic [54:0] w_prod;
    t_item       r_s2;
    logic [15:0] r_s2_q;
    logic [11:0] r_s2_h;
    logic [4:0]  r_s2_lo;

    assign w_prod = {28'd0, r_s1_us[31:5]} * {27'd0, RECIP_M};

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2    <= r_s1;
            r_s2_q  <= w_prod[RECIP_SHIFT+15:RECIP_SHIFT];
            r_s2_h  <= r_s1_us[16:5];
            r_s2_lo <= r_s1_us[4:0];
        end
    end

    // ---------------- stage 3: remainder and half-period flag ----------------
    // remainder < 4096, so 12 bits of the difference are enough
    logic [27:0] w_qd;
    logic [11:0] w_rem;
    logic        w_half;
    t_item       r_s3;
    logic        r_s3_half;

    assign w_qd   = {12'd0, r_s2_q} * {16'd0, SUB_DIV};
    assign w_rem  = r_s2_h - w_qd[11:0];
    assign w_half = (w_rem > HALF_HI) || ((w_rem == HALF_HI) && (r_s2_lo > HALF_LO));

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3      <= r_s2;
            r_s3_half <= w_half;
        end
    end

    // ---------------- stage 4: pattern state and held color ----------------
    t_level      r_red, r_green, r_blue;
    logic [1:0]  r_gyro_phase;
    logic [31:0] r_gyro_stamp;
    logic        r_config_on;
    logic [31:0] r_config_stamp;
    logic [2:0]  r_esc_step;
    logic [31:0] r_esc_stamp;
    logic        r_fail_on;
    logic [31:0] r_fail_stamp;
    logic [7:0]  r_blink_count;
    logic [31:0] r_blink_stamp;

    t_level      n_red, n_green, n_blue;
    logic [1:0]  n_gyro_phase;
    logic [31:0] n_gyro_stamp;
    logic        n_config_on;
    logic [31:0] n_config_stamp;
    logic [2:0]  n_esc_step;
    logic [31:0] n_esc_stamp;
    logic        n_fail_on;
    logic [31:0] n_fail_stamp;
    logic [7:0]  n_blink_count;
    logic [31:0] n_blink_stamp;

    always_comb begin
        logic [31:0] now;
        logic [7:0]  old_cnt;
        logic [7:0]  inc_cnt;
        logic        wrap;

        n_red          = r_red;
        n_green        = r_green;
        n_blue         = r_blue;
        n_gyro_phase   = r_gyro_phase;
        n_gyro_stamp   = r_gyro_stamp;
        n_config_on    = r_config_on;
        n_config_stamp = r_config_stamp;
        n_esc_step     = r_esc_step;
        n_esc_stamp    = r_esc_stamp;
        n_fail_on      = r_fail_on;
        n_fail_stamp   = r_fail_stamp;
        n_blink_count  = r_blink_count;
        n_blink_stamp  = r_blink_stamp;

        now     = r_s3.now;
        old_cnt = r_blink_count;
        inc_cnt = r_blink_count + 8'd1;
        wrap    = r_s3.eight ? (old_cnt > BLINK_LIMIT_8)
                             : (old_cnt > {1'b0, r_s3.sats, 1'b0});

        unique case (r_s3.cmd)
            CMD_GPS: begin
                if (r_s3.bad) begin
                    // fail blink: toggle red
                    if (due(now, r_fail_stamp, r_gps_fail_ms)) begin
                        n_fail_on    = !r_fail_on;
                        n_fail_stamp = now;
                    end
                    n_red   = n_fail_on ? r_full_level : LVL_OFF;
                    n_green = LVL_OFF;
                    n_blue  = LVL_OFF;
                end else if (r_s3.rth) begin
                    // RTH: blue during second half of each 100 ms
                    n_red   = LVL_OFF;
                    n_green = LVL_OFF;
                    n_blue  = r_s3_half ? r_full_level : LVL_OFF;
                end else if (!due(now, r_blink_stamp, r_gps_blink_ms)) begin
                    n_red   = LVL_OFF;
                    n_green = LVL_OFF;
                    n_blue  = LVL_OFF;
                end else begin
                    // satellite count flashes
                    if (r_s3.good) begin
                        n_blink_count = wrap ? 8'd0 : inc_cnt;
                        if (n_blink_count >= BLINK_GREEN_MIN && !n_blink_count[0]) begin
                            n_red   = LVL_OFF;
                            n_green = r_full_level;
                            n_blue  = LVL_OFF;
                        end
                        if (n_blink_count == BLINK_HOME) begin
                            n_red   = LVL_OFF;
                            n_green = LVL_OFF;
                            n_blue  = r_full_level;
                        end
                    end else begin
                        n_blink_count = 8'd0;
                    end
                    n_blink_stamp = now;
                end
            end
            CMD_ACC_CAL: begin
                n_red   = LVL_OFF;
                n_green = r_full_level;
                n_blue  = LVL_BLUE;
            end
            CMD_MAG_CAL: begin
                n_red   = LVL_RED_LO;
                n_green = LVL_OFF;
                n_blue  = LVL_BLUE;
            end
            CMD_CONFIG: begin
                if (due(now, r_config_stamp, r_config_blink_ms)) begin
                    n_config_on    = !r_config_on;
                    n_config_stamp = now;
                end
                n_red   = n_config_on ? LVL_YEL_R : LVL_OFF;
                n_green = n_config_on ? LVL_YEL_G : LVL_OFF;
                n_blue  = LVL_OFF;
            end
            CMD_ESC: begin
                if (due(now, r_esc_stamp, r_esc_step_ms)) begin
                    n_esc_step  = r_esc_step + 3'd1;
                    n_esc_stamp = now;
                end
                // step zero and seven keep the color; six wraps back to one
                unique case (n_esc_step)
                    ESC_RED: begin
                        n_red = r_full_level; n_green = LVL_OFF; n_blue = LVL_OFF;
                    end
                    ESC_GREEN: begin
                        n_red = LVL_OFF; n_green = r_full_level; n_blue = LVL_OFF;
                    end
                    ESC_BLUE: begin
                        n_red = LVL_OFF; n_green = LVL_OFF; n_blue = r_full_level;
                    end
                    ESC_OFF_A, ESC_OFF_B: begin
                        n_red = LVL_OFF; n_green = LVL_OFF; n_blue = LVL_OFF;
                    end
                    ESC_WRAP: n_esc_step = ESC_RED;
                    default: ;
                endcase
            end
            CMD_PREARM_INIT: begin
                n_red = LVL_OFF; n_green = LVL_OFF; n_blue = r_full_level;
            end
            CMD_PREARM_OK: begin
                n_red = LVL_OFF; n_green = r_full_level; n_blue = LVL_OFF;
            end
            CMD_PREARM_FAIL: begin
                n_red = r_full_level; n_green = LVL_OFF; n_blue = LVL_OFF;
            end
            CMD_GYRO: begin
                if (due(now, r_gyro_stamp, r_gyro_step_ms)) begin
                    n_gyro_phase = r_gyro_phase + 2'd1;
                    n_gyro_stamp = now;
                end
                if (n_gyro_phase == 2'd0) begin
                    n_red = LVL_YEL_R; n_green = LVL_YEL_G; n_blue = LVL_OFF;
                end else if (n_gyro_phase == 2'd1) begin
                    n_red = LVL_RED_LO; n_green = LVL_OFF; n_blue = LVL_BLUE;
                end else begin
                    n_gyro_phase = 2'd0;
                end
            end
            default: ;  // unknown command: color held
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red          <= LVL_OFF;
            r_green        <= LVL_OFF;
            r_blue         <= LVL_OFF;
            r_gyro_phase   <= 2'd0;
            r_gyro_stamp   <= 32'd0;
            r_config_on    <= 1'b1;
            r_config_stamp <= 32'd0;
            r_esc_step     <= 3'd0;
            r_esc_stamp    <= 32'd0;
            r_fail_on      <= 1'b0;
            r_fail_stamp   <= 32'd0;
            r_blink_count  <= 8'd0;
            r_blink_stamp  <= 32'd0;
        end else if (r_v3 && w_out_free) begin
            r_red          <= n_red;
            r_green        <= n_green;
            r_blue         <= n_blue;
            r_gyro_phase   <= n_gyro_phase;
            r_gyro_stamp   <= n_gyro_stamp;
            r_config_on    <= n_config_on;
            r_config_stamp <= n_config_stamp;
            r_esc_step     <= n_esc_step;
            r_esc_stamp    <= n_esc_stamp;
            r_fail_on      <= n_fail_on;
            r_fail_stamp   <= n_fail_stamp;
            r_blink_count  <= n_blink_count;
            r_blink_stamp  <= n_blink_stamp;
        end
    end

    // held color is the result register
    assign o_out_valid   = r_out_valid;
    assign o_red_level   = r_red;
    assign o_green_level = r_green;
    assign o_blue_level  = r_blue;

endmodule

`default_nettype wire

// ===== src/rsp_checker.sv =====
// Port-level checker for the RGB status pattern generator, bound to the core.
// Depends on rsp_pkg.
`default_nettype none

module rsp_checker
    import rsp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic [3:0]         i_command,
    input wire logic [31:0]        i_now_ms,
    input wire logic [31:0]        i_now_us,
    input wire logic               i_gps_bad,
    input wire logic               i_gps_good,
    input wire logic               i_gps_eight_plus,
    input wire logic [5:0]         i_satellites,
    input wire logic               i_rth_active,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [LEVEL_W-1:0] o_red_level,
    input wire logic [LEVEL_W-1:0] o_green_level,
    input wire logic [LEVEL_W-1:0] o_blue_level,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic [2:0]         i_cfg_index,
    input wire logic [15:0]        i_cfg_data
);

    // a stalled result beat stays valid
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its color
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_red_level) && $stable(o_green_level) && $stable(o_blue_level)))
        else $error("result color changed while stalled");

    // reset leaves no result pending and the held color dark
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_red_level == '0 && o_green_level == '0
                      && o_blue_level == '0))
        else $error("reset did not clear result and held color");

    // input only backs up when the full pipe meets a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

endmodule

bind rgb_status_pattern_generator_core rsp_checker u_rsp_checker (.*);

`default_nettype wire

// ===== dv/rsp_color_check.sv =====
`timescale 1ns / 100ps
// Scoreboard for the RGB status pattern generator: follows the config and input beats,
// predicts the held color of every update and compares it with the output beats.
// Depends on rsp_pkg for the command and register index codes.

module rsp_color_check
    import rsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [3:0]  i_command,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [31:0] i_now_us,
    input  wire logic        i_gps_bad,
    input  wire logic        i_gps_good,
    input  wire logic        i_gps_eight_plus,
    input  wire logic [5:0]  i_satellites,
    input  wire logic        i_rth_active,
    // output channel
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_red_level,
    input  wire logic [7:0]  i_green_level,
    input  wire logic [7:0]  i_blue_level,
    // configuration channel
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // status to the testbench top
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        t_level red;
        t_level green;
        t_level blue;
    } t_rgb;

    // Fixed levels and limits of the patterns
    localparam t_level      LEVEL_OFF      = 8'd0;
    localparam t_level      SOFT_BLUE      = 8'd220;
    localparam t_level      MAGENTA_RED    = 8'd180;
    localparam t_level      AMBER_RED      = 8'd190;
    localparam t_level      AMBER_GREEN    = 8'd240;
    localparam logic [7:0]  SAT_CAP_EIGHT  = 8'd16;
    localparam logic [7:0]  SAT_GREEN_FROM = 8'd10;
    localparam logic [7:0]  SAT_HOME       = 8'd6;
    localparam logic [31:0] RTH_PERIOD_US  = 32'd100000;
    localparam logic [31:0] RTH_HALF_US    = 32'd50000;
    localparam int          SHOW_MAX       = 10;

    // Configuration copy
    t_level      full_lvl;
    logic [15:0] gyro_ms;
    logic [15:0] cfg_blink_ms;
    logic [15:0] esc_ms;
    logic [15:0] fail_ms;
    logic [15:0] sat_ms;

    // Pattern state
    t_rgb        held;
    logic [1:0]  gyro_phase;
    logic [31:0] gyro_t;
    logic        cfg_on;
    logic [31:0] cfg_t;
    logic [2:0]  esc_idx;
    logic [31:0] esc_t;
    logic        fail_on;
    logic [31:0] fail_t;
    logic [7:0]  sat_cnt;
    logic [31:0] sat_t;

    t_rgb        color_q[$];
    int          bad_beats = 0;

    assign o_fail_count = bad_beats;

    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] stamp,
                                     input logic [15:0] span);
        logic [31:0] diff;
        diff = now - stamp;
        return diff >= {16'd0, span};
    endfunction

    function automatic t_rgb rgb(input t_level r, input t_level g, input t_level b);
        return {r, g, b};
    endfunction

    task automatic clear_state();
        full_lvl     = FULL_LEVEL_RST;
        gyro_ms      = 16'd250;
        cfg_blink_ms = 16'd500;
        esc_ms       = 16'd170;
        fail_ms      = 16'd350;
        sat_ms       = 16'd150;
        held         = rgb(LEVEL_OFF, LEVEL_OFF, LEVEL_OFF);
        gyro_phase   = 2'd0;
        gyro_t       = 32'd0;
        cfg_on       = 1'b1;
        cfg_t        = 32'd0;
        esc_idx      = 3'd0;
        esc_t        = 32'd0;
        fail_on      = 1'b0;
        fail_t       = 32'd0;
        sat_cnt      = 8'd0;
        sat_t        = 32'd0;
    endtask

    // GPS status: fail blink, RTH blink, then satellite-count flashes
    task automatic gps_step();
        logic [7:0] prev;
        logic       wrap;
        if (i_gps_bad) begin
            if (elapsed(i_now_ms, fail_t, fail_ms)) begin
                fail_on = ~fail_on;
                fail_t  = i_now_ms;
            end
            held = fail_on ? rgb(full_lvl, LEVEL_OFF, LEVEL_OFF)
                           : rgb(LEVEL_OFF, LEVEL_OFF, LEVEL_OFF);
        end else if (i_rth_active) begin
            held = ((i_now_us % RTH_PERIOD_US) > RTH_HALF_US)
                   ? rgb(LEVEL_OFF, LEVEL_OFF, full_lvl)
                   : rgb(LEVEL_OFF, LEVEL_OFF, LEVEL_OFF);
        end else if (!elapsed(i_now_ms, sat_t, sat_ms)) begin
            held = rgb(LEVEL_OFF, LEVEL_OFF, LEVEL_OFF);
        end else begin
            if (i_gps_good) begin
                prev    = sat_cnt;
                sat_cnt = sat_cnt + 8'd1;
                // limit is twice the count unless eight or more are tracked
                wrap = i_gps_eight_plus ? (prev > SAT_CAP_EIGHT)
                                        : (prev > {1'b0, i_satellites, 1'b0});
                if (wrap) sat_cnt = 8'd0;
                if (sat_cnt >= SAT_GREEN_FROM && !sat_cnt[0])
                    held = rgb(LEVEL_OFF, full_lvl, LEVEL_OFF);
                if (sat_cnt == SAT_HOME)
                    held = rgb(LEVEL_OFF, LEVEL_OFF, full_lvl);
            end else begin
                sat_cnt = 8'd0;
            end
            sat_t = i_now_ms;
        end
    endtask

    // One update call; unknown commands leave the held color alone
    task automatic advance_pattern();
        case (i_command)
            CMD_GPS:         gps_step();
            CMD_ACC_CAL:     held = rgb(LEVEL_OFF, full_lvl, SOFT_BLUE);
            CMD_MAG_CAL:     held = rgb(MAGENTA_RED, LEVEL_OFF, SOFT_BLUE);
            CMD_CONFIG: begin
                if (elapsed(i_now_ms, cfg_t, cfg_blink_ms)) begin
                    cfg_on = ~cfg_on;
                    cfg_t  = i_now_ms;
                end
                held = cfg_on ? rgb(AMBER_RED, AMBER_GREEN, LEVEL_OFF)
                              : rgb(LEVEL_OFF, LEVEL_OFF, LEVEL_OFF);
            end
            CMD_ESC: begin
                if (elapsed(i_now_ms, esc_t, esc_ms)) begin
                    esc_idx = esc_idx + 3'd1;
                    esc_t   = i_now_ms;
                end
                case (esc_idx)
                    ESC_RED:            held = rgb(full_lvl, LEVEL_OFF, LEVEL_OFF);
                    ESC_GREEN:          held = rgb(LEVEL_OFF, full_lvl, LEVEL_OFF);
                    ESC_BLUE:           held = rgb(LEVEL_OFF, LEVEL_OFF, full_lvl);
                    ESC_OFF_A, ESC_OFF_B: held = rgb(LEVEL_OFF, LEVEL_OFF, LEVEL_OFF);
                    ESC_WRAP:           esc_idx = ESC_RED;
                    default: ;
                endcase
            end
            CMD_PREARM_INIT: held = rgb(LEVEL_OFF, LEVEL_OFF, full_lvl);
            CMD_PREARM_OK:   held = rgb(LEVEL_OFF, full_lvl, LEVEL_OFF);
            CMD_PREARM_FAIL: held = rgb(full_lvl, LEVEL_OFF, LEVEL_OFF);
            CMD_GYRO: begin
                if (elapsed(i_now_ms, gyro_t, gyro_ms)) begin
                    gyro_phase = gyro_phase + 2'd1;
                    gyro_t     = i_now_ms;
                end
                if (gyro_phase == 2'd0)
                    held = rgb(AMBER_RED, AMBER_GREEN, LEVEL_OFF);
                else if (gyro_phase == 2'd1)
                    held = rgb(MAGENTA_RED, LEVEL_OFF, SOFT_BLUE);
                else
                    gyro_phase = 2'd0;
            end
            default: ;
        endcase
    endtask

    // Register writes, input beats and output beats, all sampled at the edge
    always @(posedge i_clk) begin : watch
        t_rgb got;
        t_rgb want;
        if (!i_rst_n) begin
            clear_state();
            color_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FULL_LEVEL:   full_lvl     = i_cfg_data[7:0];
                    CFG_GYRO_STEP:    gyro_ms      = i_cfg_data;
                    CFG_CONFIG_BLINK: cfg_blink_ms = i_cfg_data;
                    CFG_ESC_STEP:     esc_ms       = i_cfg_data;
                    CFG_GPS_FAIL:     fail_ms      = i_cfg_data;
                    CFG_GPS_BLINK:    sat_ms       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_pattern();
                color_q.push_back(held);
            end
            if (i_out_valid && !i_out_stall) begin
                got = rgb(i_red_level, i_green_level, i_blue_level);
                if (color_q.size() == 0) begin
                    if (bad_beats < SHOW_MAX)
                        $display("%0t: output beat r=%0d g=%0d b=%0d with none expected",
                                 $realtime, got.red, got.green, got.blue);
                    bad_beats++;
                end else begin
                    want = color_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        if (bad_beats < SHOW_MAX)
                            $display("%0t: color mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        bad_beats++;
                    end
                end
            end
        end
        o_pending <= color_q.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for rgb_status_pattern_generator_core: drives update and config beats,
// stalls the output at random and gives the verdict. Depends on rsp_pkg, rsp_color_check.

module tb;
    import rsp_pkg::*;

    localparam int         IDLE_LIMIT      = 2000;
    localparam int         DRAIN_CYCLES    = 12;
    localparam int         HOLD_CYCLES     = 120;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 112;
    localparam logic [2:0] CFG_SPARE_A     = 3'd6;
    localparam logic [2:0] CFG_SPARE_B     = 3'd7;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic [3:0]  i_command        = 4'd0;
    logic [31:0] i_now_ms         = 32'd0;
    logic [31:0] i_now_us         = 32'd0;
    logic        i_gps_bad        = 1'b0;
    logic        i_gps_good       = 1'b0;
    logic        i_gps_eight_plus = 1'b0;
    logic [5:0]  i_satellites     = 6'd0;
    logic        i_rth_active     = 1'b0;
    logic        i_out_stall      = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic [2:0]  i_cfg_index      = 3'd0;
    logic [15:0] i_cfg_data       = 16'd0;

    wire logic         o_in_stall;
    wire logic         o_out_valid;
    wire logic [7:0]   o_red_level;
    wire logic [7:0]   o_green_level;
    wire logic [7:0]   o_blue_level;
    wire logic         o_cfg_ready;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    logic        hold_req    = 1'b0;
    logic        pressure_on = 1'b0;
    logic [2:0]  reg_idx_q[$];
    logic [15:0] reg_val_q[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    rgb_status_pattern_generator_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_now_ms         (i_now_ms),
        .i_now_us         (i_now_us),
        .i_gps_bad        (i_gps_bad),
        .i_gps_good       (i_gps_good),
        .i_gps_eight_plus (i_gps_eight_plus),
        .i_satellites     (i_satellites),
        .i_rth_active     (i_rth_active),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_red_level      (o_red_level),
        .o_green_level    (o_green_level),
        .o_blue_level     (o_blue_level),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    rsp_color_check u_color_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_now_ms         (i_now_ms),
        .i_now_us         (i_now_us),
        .i_gps_bad        (i_gps_bad),
        .i_gps_good       (i_gps_good),
        .i_gps_eight_plus (i_gps_eight_plus),
        .i_satellites     (i_satellites),
        .i_rth_active     (i_rth_active),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_red_level      (o_red_level),
        .i_green_level    (o_green_level),
        .i_blue_level     (o_blue_level),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Watchdog: cycles in a row with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output stall: runs of open and stalled cycles, plus one long hold-off
    initial begin : out_stall_gen
        int pick;
        int len;
        bit stall;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                pressure_on <= 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                pressure_on <= 1'b0;
                hold_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    stall = 1'b0;
                    len   = $urandom_range(1, 30);
                end else begin
                    stall = 1'b1;
                    if (pick < 90)      len = $urandom_range(1, 3);
                    else if (pick < 98) len = $urandom_range(4, 12);
                    else                len = $urandom_range(20, 60);
                end
                i_out_stall <= stall;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // Idle cycles before an input beat; none while the output is held off
    function automatic int pick_gap(input bit calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (pressure_on || calm) return 0;
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [31:0] ms_step();
        if ($urandom_range(0, 39) == 0) return $urandom();
        return $urandom_range(0, 320);
    endfunction

    // One update beat; called right after the edge that took the previous one
    task automatic send_item(input logic [3:0] cmd, input logic [31:0] ms,
                             input logic [31:0] us, input logic bad, input logic good,
                             input logic eight, input logic [5:0] sats, input logic rth,
                             input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_now_ms         <= ms;
        i_now_us         <= us;
        i_gps_bad        <= bad;
        i_gps_good       <= good;
        i_gps_eight_plus <= eight;
        i_satellites     <= sats;
        i_rth_active     <= rth;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic add_reg(input logic [2:0] idx, input logic [15:0] val);
        reg_idx_q.push_back(idx);
        reg_val_q.push_back(val);
    endtask

    // Queued register writes, back to back
    task automatic load_regs();
        logic [2:0]  idx;
        logic [15:0] val;
        while (reg_idx_q.size() > 0) begin
            idx = reg_idx_q.pop_front();
            val = reg_val_q.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every predicted color has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Register settings per phase: extremes first, then defaults, then random
    task automatic choose_settings(input int ph);
        int k;
        logic [15:0] span;
        case (ph)
            0: begin
                add_reg(CFG_FULL_LEVEL, {8'($urandom()), 8'hFF});
                for (k = CFG_GYRO_STEP; k <= CFG_GPS_BLINK; k++) add_reg(3'(k), 16'd0);
                add_reg(CFG_SPARE_A, 16'($urandom()));
                add_reg(CFG_SPARE_B, 16'($urandom()));
            end
            1: begin
                add_reg(CFG_FULL_LEVEL, {8'($urandom()), 8'h00});
                for (k = CFG_GYRO_STEP; k <= CFG_GPS_BLINK; k++) add_reg(3'(k), 16'hFFFF);
            end
            2: begin
                add_reg(CFG_FULL_LEVEL, 16'hFF01);
                for (k = CFG_GYRO_STEP; k <= CFG_GPS_BLINK; k++) add_reg(3'(k), 16'd1);
            end
            3: begin
                add_reg(CFG_FULL_LEVEL,   {8'd0, FULL_LEVEL_RST});
                add_reg(CFG_GYRO_STEP,    GYRO_STEP_RST);
                add_reg(CFG_CONFIG_BLINK, CONFIG_BLINK_RST);
                add_reg(CFG_ESC_STEP,     ESC_STEP_RST);
                add_reg(CFG_GPS_FAIL,     GPS_FAIL_RST);
                add_reg(CFG_GPS_BLINK,    GPS_BLINK_RST);
            end
            default: begin
                add_reg(CFG_FULL_LEVEL, 16'($urandom()));
                for (k = CFG_GYRO_STEP; k <= CFG_GPS_BLINK; k++) begin
                    case ($urandom_range(0, 3))
                        0:       span = 16'($urandom_range(0, 20));
                        1:       span = 16'($urandom_range(1, 65535));
                        default: span = 16'($urandom_range(1, 400));
                    endcase
                    add_reg(3'(k), span);
                end
            end
        endcase
    endtask

    initial begin : stim
        int          ph;
        int          sent;
        int          burst;
        int          j;
        int          pick;
        int          profile;
        bit          calm;
        logic [3:0]  cmd;
        logic [3:0]  item_cmd;
        logic [31:0] clock_ms;
        logic [31:0] clock_us;
        logic        bad;
        logic        good;
        logic        eight;
        logic        rth;
        logic [5:0]  sats;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: default registers, stamps still at zero
        // ESC before its first step keeps the reset color; unknown commands too
        send_item(CMD_ESC,         32'd0,  32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(4'd15,           32'd5,  32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_ACC_CAL,     32'd10, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(4'd9,            32'd11, 32'd0, 1'b1, 1'b1, 1'b1, 6'd63, 1'b1,
                  pick_gap(1'b0));
        send_item(CMD_MAG_CAL,     32'd12, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_PREARM_INIT, 32'd13, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_PREARM_OK,   32'd14, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_PREARM_FAIL, 32'd15, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        // gyro: phase one, phase two folds back and keeps the color, then phase zero
        send_item(CMD_GYRO,        32'd250, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_GYRO,        32'd500, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_GYRO,        32'd600, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_CONFIG,      32'd100, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_CONFIG,      32'd600, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        // ESC flasher through its wrap step and on
        for (j = 1; j <= 7; j++)
            send_item(CMD_ESC, 32'(200 * j), 32'd0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0,
                      pick_gap(1'b0));
        // GPS: fail blink, RTH blink around the half period, not due, not good
        send_item(CMD_GPS, 32'd400, 32'd0, 1'b1, 1'b0, 1'b0, 6'd0, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_GPS, 32'd500, 32'd50001, 1'b0, 1'b1, 1'b0, 6'd5, 1'b1,
                  pick_gap(1'b0));
        send_item(CMD_GPS, 32'd500, 32'd50000, 1'b0, 1'b1, 1'b0, 6'd5, 1'b1,
                  pick_gap(1'b0));
        send_item(CMD_GPS, 32'd500, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 6'd0, 1'b1,
                  pick_gap(1'b0));
        send_item(CMD_GPS, 32'd100, 32'd0, 1'b0, 1'b1, 1'b0, 6'd3, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_GPS, 32'd200, 32'd0, 1'b0, 1'b0, 1'b0, 6'd3, 1'b0,
                  pick_gap(1'b0));
        send_item(CMD_GPS, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1, 1'b1, 6'd63, 1'b0,
                  pick_gap(1'b0));

        clock_ms = 32'hFFFF_FFFF;
        clock_us = $urandom();

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            choose_settings(ph);
            load_regs();
            if (ph == 2) hold_req = 1'b1;
            if (ph == 5) clock_ms = 32'hFFFF_FF00;

            // Bursts of one pattern with advancing time, some noise mixed in
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)      cmd = CMD_GPS;
                else if (pick < 52) cmd = CMD_ESC;
                else if (pick < 64) cmd = CMD_GYRO;
                else if (pick < 76) cmd = CMD_CONFIG;
                else if (pick < 92) begin
                    case ($urandom_range(0, 4))
                        0:       cmd = CMD_ACC_CAL;
                        1:       cmd = CMD_MAG_CAL;
                        2:       cmd = CMD_PREARM_INIT;
                        3:       cmd = CMD_PREARM_OK;
                        default: cmd = CMD_PREARM_FAIL;
                    endcase
                end else begin
                    cmd = 4'($urandom_range(9, 15));
                end
                burst   = (cmd == CMD_GPS) ? $urandom_range(8, 60) : $urandom_range(1, 25);
                calm    = ($urandom_range(0, 3) == 0);
                profile = $urandom_range(0, 9);
                sats    = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'($urandom_range(0, 10));
                eight   = 1'($urandom_range(0, 1));
                for (j = 0; j < burst; j++) begin
                    clock_ms = clock_ms + ms_step();
                    clock_us = ($urandom_range(0, 29) == 0) ? $urandom()
                               : clock_us + 32'($urandom_range(0, 70000));
                    bad  = 1'b0;
                    good = 1'b1;
                    rth  = 1'b0;
                    case (profile)
                        6: begin
                            bad  = 1'b1;
                            good = 1'($urandom_range(0, 1));
                            rth  = 1'($urandom_range(0, 1));
                        end
                        7: rth = 1'b1;
                        8, 9: begin
                            bad   = 1'($urandom_range(0, 1));
                            good  = 1'($urandom_range(0, 1));
                            rth   = 1'($urandom_range(0, 1));
                            eight = 1'($urandom_range(0, 1));
                            sats  = 6'($urandom_range(0, 63));
                        end
                        default: good = ($urandom_range(0, 11) != 0);
                    endcase
                    item_cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : cmd;
                    send_item(item_cmd, clock_ms, clock_us, bad, good, eight, sats, rth,
                              pick_gap(calm));
                end
                sent += burst;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
